// File: design/quaternion_vector_rotate_defines.svh
// Assertion macros shared by the checker of the quaternion rotation block.
`ifndef QUATERNION_VECTOR_ROTATE_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define QVR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion rotate check failed");
// Next-cycle implication checked outside reset.
`define QVR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion rotate check failed");
`endif

// File: design/qvr_pkg.sv
// Package with types, constants and the divider step of the quaternion rotation block.
package qvr_pkg;

    localparam int QBITS  = 32;
    localparam int DSTAGE = QBITS;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] lo;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } lane_t;

    // One restoring division step: brings in the next dividend bit.
    function automatic lane_t div_step(lane_t a, logic [32:0] n);
        lane_t       r;
        logic [33:0] t;
        logic [33:0] d;
        r = a;
        t = {a.rem, a.lo[31]};
        d = t - {1'b0, n};
        if (t >= {1'b0, n})
        begin
            r.rem = d[32:0];
            r.quo = {a.quo[30:0], 1'b1};
        end
        else
        begin
            r.rem = t[32:0];
            r.quo = {a.quo[30:0], 1'b0};
        end
        r.lo = {a.lo[30:0], 1'b0};
        return r;
    endfunction

endpackage

// File: design/qvr_if.sv
// Handshake interfaces for the input and output words of the rotation block.
interface qvr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rot_w;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    modport source (output valid, rot_w, rot_x, rot_y, rot_z, vec_x, vec_y, vec_z,
                    input ready);
    modport sink (input valid, rot_w, rot_x, rot_y, rot_z, vec_x, vec_y, vec_z,
                  output ready);
endinterface

interface qvr_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic        [1:0]  status;
    modport source (output valid, out_x, out_y, out_z, status, input ready);
    modport sink (input valid, out_x, out_y, out_z, status, output ready);
endinterface

// File: design/quaternion_vector_rotate.sv
// Top level of the pipelined quaternion vector rotation block.
//
//  Channel   Dir   Contents
//  in_ch     in    rot_w..rot_z (Q1.14), vec_x..vec_z (Q16.16)
//  out_ch    out   out_x..out_z (Q16.16, saturated), status
//
// One word enters per cycle while the sink is not holding the output word;
// each word passes through six capture and arithmetic stages, a 32-stage
// restoring divider (one quotient bit per stage) and the output register.
// Reset clears only the valid bits of the stages.
// When the output word is held by the sink, the whole pipeline freezes, so
// no word is lost or repeated; in_ch.ready is low only during such a stall.
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    qvr_in_if.sink    in_ch,
    qvr_out_if.source out_ch
);

    localparam int NVLD = 6 + DSTAGE + 1;

    // The pipeline moves as a whole whenever the output slot is free or taken.
    logic adv;
    logic [NVLD-1:0] vld_reg;

    assign adv         = !vld_reg[NVLD-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NVLD-2:0], in_ch.valid};
    end

    // Stage 1: capture the input word.
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0] v1_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qw_reg    <= in_ch.rot_w;
            qx_reg    <= in_ch.rot_x;
            qy_reg    <= in_ch.rot_y;
            qz_reg    <= in_ch.rot_z;
            v1_reg[0] <= in_ch.vec_x;
            v1_reg[1] <= in_ch.vec_y;
            v1_reg[2] <= in_ch.vec_z;
        end
    end

    // Stage 2: the ten quaternion products.
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, wz_reg;
    logic signed [31:0] xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [31:0] v2_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= qw_reg * qw_reg;
            xx_reg <= qx_reg * qx_reg;
            yy_reg <= qy_reg * qy_reg;
            zz_reg <= qz_reg * qz_reg;
            xy_reg <= qx_reg * qy_reg;
            wz_reg <= qw_reg * qz_reg;
            xz_reg <= qx_reg * qz_reg;
            wy_reg <= qw_reg * qy_reg;
            yz_reg <= qy_reg * qz_reg;
            wx_reg <= qw_reg * qx_reg;
            v2_reg <= v1_reg;
        end
    end

    // Stage 3: the unnormalized rotation matrix and the squared norm.
    logic signed [33:0] ww_e, xx_e, yy_e, zz_e, xy_e, wz_e, xz_e, wy_e, yz_e, wx_e;
    logic signed [33:0] c_next [9];
    logic signed [33:0] c_reg  [9];
    logic        [32:0] n3_reg;
    logic signed [31:0] v3_reg [3];

    always_comb
    begin
        ww_e = 34'(ww_reg);
        xx_e = 34'(xx_reg);
        yy_e = 34'(yy_reg);
        zz_e = 34'(zz_reg);
        xy_e = 34'(xy_reg);
        wz_e = 34'(wz_reg);
        xz_e = 34'(xz_reg);
        wy_e = 34'(wy_reg);
        yz_e = 34'(yz_reg);
        wx_e = 34'(wx_reg);
        c_next[0] = ww_e + xx_e - yy_e - zz_e;
        c_next[1] = (xy_e - wz_e) <<< 1;
        c_next[2] = (xz_e + wy_e) <<< 1;
        c_next[3] = (xy_e + wz_e) <<< 1;
        c_next[4] = ww_e - xx_e + yy_e - zz_e;
        c_next[5] = (yz_e - wx_e) <<< 1;
        c_next[6] = (xz_e - wy_e) <<< 1;
        c_next[7] = (yz_e + wx_e) <<< 1;
        c_next[8] = ww_e - xx_e - yy_e + zz_e;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg  <= c_next;
            n3_reg <= 33'(ww_reg) + 33'(xx_reg) + 33'(yy_reg) + 33'(zz_reg);
            v3_reg <= v2_reg;
        end
    end

    // Stage 4: matrix times vector, nine products.
    logic signed [65:0] m_reg [9];
    logic        [32:0] n4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 9; i++)
                m_reg[i] <= 66'(c_reg[i]) * 66'(v3_reg[i % 3]);
            n4_reg <= n3_reg;
        end
    end

    // Stage 5: row sums.
    logic signed [67:0] s_reg [3];
    logic        [32:0] n5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                s_reg[r] <= 68'(m_reg[3*r]) + 68'(m_reg[3*r+1]) + 68'(m_reg[3*r+2]);
            n5_reg <= n4_reg;
        end
    end

    // Stage 6: magnitude, sign and the quotient-overflow test that seed the divider.
    lane_t       ln_next [3];
    logic [67:0] mag     [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            mag[r]           = s_reg[r][67] ? 68'(-s_reg[r]) : 68'(s_reg[r]);
            ln_next[r].neg   = s_reg[r][67];
            ln_next[r].ovf   = mag[r] >= {3'b000, n5_reg, 32'h0};
            ln_next[r].rem   = mag[r][64:32];
            ln_next[r].lo    = mag[r][31:0];
            ln_next[r].quo   = '0;
        end
    end

    lane_t       ln_reg [DSTAGE+1][3];
    logic [32:0] nd_reg [DSTAGE+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ln_reg[0] <= ln_next;
            nd_reg[0] <= n5_reg;
        end
    end

    // Divider: each stage resolves one quotient bit for all three rows.
    for (genvar k = 0; k < DSTAGE; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                for (int r = 0; r < 3; r++)
                    ln_reg[k+1][r] <= div_step(ln_reg[k][r], nd_reg[k]);
                nd_reg[k+1] <= nd_reg[k];
            end
        end
    end

    // Output stage: sign, saturation and status.
    logic [31:0] o_next [3];
    logic        sat_any;
    status_t     st_next;
    logic [31:0] o_reg  [3];
    status_t     st_reg;

    always_comb
    begin
        sat_any = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            lane_t l;
            l = ln_reg[DSTAGE][r];
            if (!l.neg)
            begin
                if (l.ovf || l.quo > 32'h7FFF_FFFF)
                begin
                    o_next[r] = 32'h7FFF_FFFF;
                    sat_any   = 1'b1;
                end
                else
                    o_next[r] = l.quo;
            end
            else
            begin
                if (l.ovf || l.quo > 32'h8000_0000)
                begin
                    o_next[r] = 32'h8000_0000;
                    sat_any   = 1'b1;
                end
                else
                    o_next[r] = 32'h0 - l.quo;
            end
        end
        // A zero quaternion overrides everything the divider produced.
        if (nd_reg[DSTAGE] == '0)
        begin
            for (int r = 0; r < 3; r++)
                o_next[r] = '0;
            st_next = STATUS_ZERO;
        end
        else if (sat_any)
            st_next = STATUS_SAT;
        else
            st_next = STATUS_OK;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg  <= o_next;
            st_reg <= st_next;
        end
    end

    assign out_ch.valid  = vld_reg[NVLD-1];
    assign out_ch.out_x  = o_reg[0];
    assign out_ch.out_y  = o_reg[1];
    assign out_ch.out_z  = o_reg[2];
    assign out_ch.status = st_reg;

endmodule

// File: design/qvr_checker.sv
// Port-level checker of the rotation block and its bind.
`include "quaternion_vector_rotate_defines.svh"
module qvr_checker
    import qvr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_y,
    input logic [31:0] out_z,
    input logic [1:0]  status
);

    `QVR_ASSERT_IMP(a_code, out_valid, status != 2'd3)
    `QVR_ASSERT_IMP(a_zero, out_valid && status == STATUS_ZERO, (out_x | out_y | out_z) == '0)
    `QVR_ASSERT_IMP(a_ready, !out_valid || out_ready, in_ready)
    `QVR_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(status))

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_z     (out_ch.out_z),
    .status    (out_ch.status)
);
